>>> hdl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// Touch point tracker package
// Field widths, event and command codes, controller states and the command
// and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tpt_pkg;

   localparam int STATUS_W = 8;
   localparam int ID_W     = 8;
   localparam int COORD_W  = 16;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 4;

   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

   localparam logic CMD_FRAME  = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

   localparam int                  READY_BIT  = 7;
   localparam logic [STATUS_W-1:0] COUNT_MASK = 8'h0f;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_PRESS  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_CLEAR  = 5'b10000
   } state_type;

   typedef struct packed {
      logic latch_item;
      logic frame_reset;
      logic frame_open;
      logic record;
      logic scan_start;
      logic scan_all;
      logic scan_next;
      logic commit;
      logic clear_stored;
      logic load_press;
      logic load_release;
      logic load_clear;
   } cmd_type;

   typedef struct packed {
      logic is_frame;
      logic status_zero;
      logic status_bad;
      logic count_zero;
      logic frame_ok;
      logic press_hit;
      logic done_next;
      logic frame_done;
      logic scan_end;
      logic scan_emit;
      logic scan_all;
      logic out_free;
   } status_type;

endpackage

>>> hdl/touch_point_press_release_tracker.sv
// ----------------------------------------------------------------------------
// Touch point press/release tracker
// Turns frame-start and point-record items into press, release and
// status-clear events by comparing each frame's IDs with the stored set.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_tvalid/req_tready   command, status, id, x, y
//   rsp_      out        rsp_tvalid/rsp_tready   kind, id, row, column, last
//   csr_      in         csr_wr_en               continuous_mode
//
// An item is taken in one cycle and decoded in the next; a record that
// gives a press then passes through the press state. The release scan walks
// the stored points one per cycle, holding on a point whose release waits
// for a free result register; a closing record or an empty frame ends with
// the scan and a status clear. Reset is synchronous and clears the stored
// set. A stalled result holds the controller in its current state.
// ----------------------------------------------------------------------------
module touch_point_press_release_tracker #(
   parameter int MAX_POINTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // status_byte, point_id, point_x, point_y
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // event_id, row, column
   output logic [1:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   tpt_pkg::cmd_type    cmd;
   tpt_pkg::status_type sts;

   tpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tpt_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_press, cmd.load_release, cmd.load_clear}))
      else $error("More than one result loaded in one cycle.");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_press || cmd.load_release || cmd.load_clear) |-> sts.out_free)
      else $error("Result loaded over a waiting result.");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Item accepted while the previous one is being decoded.");

   a_release_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tpt_pkg::KIND_RELEASE) |-> !rsp_tlast)
      else $error("Release marked as the final result of an item.");

endmodule

>>> hdl/tpt_ctrl.sv
// ----------------------------------------------------------------------------
// Touch point tracker controller
// Sequences one item at a time: decode, press, release scan and clear.
// ----------------------------------------------------------------------------
module tpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tpt_pkg::status_type sts,
   output tpt_pkg::cmd_type    cmd
);

   tpt_pkg::state_type state_ff;
   tpt_pkg::state_type state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == tpt_pkg::ST_IDLE);
      case (state_ff)
         tpt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in       = tpt_pkg::ST_DECODE;
            end
         end
         tpt_pkg::ST_DECODE: begin
            if (sts.is_frame) begin
               cmd.frame_reset = 1'b1;
               if (sts.status_zero) begin
                  state_in = tpt_pkg::ST_IDLE;
               end else if (sts.status_bad) begin
                  state_in = tpt_pkg::ST_CLEAR;
               end else if (sts.count_zero) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_all   = 1'b1;
                  state_in       = tpt_pkg::ST_SCAN;
               end else begin
                  cmd.frame_open = 1'b1;
                  state_in       = tpt_pkg::ST_IDLE;
               end
            end else if (!sts.frame_ok) begin
               state_in = tpt_pkg::ST_IDLE;
            end else begin
               cmd.record = 1'b1;
               if (sts.press_hit) begin
                  state_in = tpt_pkg::ST_PRESS;
               end else if (sts.done_next) begin
                  cmd.scan_start = 1'b1;
                  state_in       = tpt_pkg::ST_SCAN;
               end else begin
                  state_in = tpt_pkg::ST_IDLE;
               end
            end
         end
         tpt_pkg::ST_PRESS: begin
            if (sts.out_free) begin
               cmd.load_press = 1'b1;
               if (sts.frame_done) begin
                  cmd.scan_start = 1'b1;
                  state_in       = tpt_pkg::ST_SCAN;
               end else begin
                  state_in = tpt_pkg::ST_IDLE;
               end
            end
         end
         tpt_pkg::ST_SCAN: begin
            if (sts.scan_end) begin
               if (sts.scan_all) begin
                  cmd.clear_stored = 1'b1;
               end else begin
                  cmd.commit = 1'b1;
               end
               state_in = tpt_pkg::ST_CLEAR;
            end else if (!sts.scan_emit) begin
               cmd.scan_next = 1'b1;
            end else if (sts.out_free) begin
               cmd.load_release = 1'b1;
               cmd.scan_next    = 1'b1;
            end
         end
         tpt_pkg::ST_CLEAR: begin
            if (sts.out_free) begin
               cmd.load_clear = 1'b1;
               state_in       = tpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/tpt_datapath.sv
// ----------------------------------------------------------------------------
// Touch point tracker datapath
// Holds the item, the frame counters, the stored and current point sets,
// the seen flags, the release scan pointer and the result register.
// ----------------------------------------------------------------------------
module tpt_datapath #(
   parameter int MAX_POINTS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tuser,
   input  logic [47:0]         req_tdata,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  tpt_pkg::cmd_type    cmd,
   output tpt_pkg::status_type sts,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   localparam int CW = $clog2(MAX_POINTS + 1);

   logic                            item_cmd_ff, item_cmd_in;
   logic [tpt_pkg::STATUS_W-1:0]    item_status_ff, item_status_in;
   logic [tpt_pkg::ID_W-1:0]        item_id_ff, item_id_in;
   logic [tpt_pkg::COORD_W-1:0]     item_x_ff, item_x_in;
   logic [tpt_pkg::COORD_W-1:0]     item_y_ff, item_y_in;

   logic                            continuous_ff, continuous_in;
   logic                            open_ff, open_in;
   logic [CW-1:0]                   expected_ff, expected_in;
   logic [CW-1:0]                   received_ff, received_in;
   logic [CW-1:0]                   stored_count_ff, stored_count_in;
   logic [CW-1:0]                   scan_ff, scan_in;
   logic                            scan_all_ff, scan_all_in;
   logic [MAX_POINTS-1:0]           seen_ff, seen_in;

   logic [tpt_pkg::ID_W-1:0]        stored_id_ff [MAX_POINTS];
   logic [tpt_pkg::ID_W-1:0]        stored_id_in [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     stored_x_ff [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     stored_x_in [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     stored_y_ff [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     stored_y_in [MAX_POINTS];
   logic [tpt_pkg::ID_W-1:0]        cur_id_ff [MAX_POINTS];
   logic [tpt_pkg::ID_W-1:0]        cur_id_in [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     cur_x_ff [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     cur_x_in [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     cur_y_ff [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0]     cur_y_in [MAX_POINTS];

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tpt_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [tpt_pkg::ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [tpt_pkg::COORD_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tpt_pkg::COORD_W-1:0]     rsp_col_ff, rsp_col_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [tpt_pkg::STATUS_W-1:0]    status_masked;
   logic [tpt_pkg::COUNT_W-1:0]     count;
   logic [MAX_POINTS-1:0]           match;
   logic                            sel_seen;
   logic [tpt_pkg::ID_W-1:0]        sel_id;
   logic [tpt_pkg::COORD_W-1:0]     sel_x;
   logic [tpt_pkg::COORD_W-1:0]     sel_y;
   logic                            out_free;

   assign status_masked = item_status_ff & tpt_pkg::COUNT_MASK;
   assign count         = status_masked[tpt_pkg::COUNT_W-1:0];
   assign out_free      = !rsp_valid_ff || rsp_tready;

   always_comb begin
      match    = '0;
      sel_seen = 1'b0;
      sel_id   = '0;
      sel_x    = '0;
      sel_y    = '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         match[i] = (CW'(i) < stored_count_ff) && (stored_id_ff[i] == item_id_ff);
         if (CW'(i) == scan_ff) begin
            sel_seen = seen_ff[i];
            sel_id   = stored_id_ff[i];
            sel_x    = stored_x_ff[i];
            sel_y    = stored_y_ff[i];
         end
      end
   end

   always_comb begin
      sts.is_frame    = (item_cmd_ff == tpt_pkg::CMD_FRAME);
      sts.status_zero = (item_status_ff == '0);
      sts.status_bad  = !item_status_ff[tpt_pkg::READY_BIT]
                        || ({1'b0, count} > (tpt_pkg::COUNT_W + 1)'(MAX_POINTS));
      sts.count_zero  = (count == '0);
      sts.frame_ok    = open_ff && (received_ff < CW'(MAX_POINTS));
      sts.press_hit   = continuous_ff || !(|match);
      sts.done_next   = (({1'b0, received_ff} + 1'b1) >= {1'b0, expected_ff});
      sts.frame_done  = (received_ff >= expected_ff);
      sts.scan_end    = (scan_ff >= stored_count_ff);
      sts.scan_emit   = scan_all_ff || !sel_seen;
      sts.scan_all    = scan_all_ff;
      sts.out_free    = out_free;
   end

   always_comb begin
      item_cmd_in     = item_cmd_ff;
      item_status_in  = item_status_ff;
      item_id_in      = item_id_ff;
      item_x_in       = item_x_ff;
      item_y_in       = item_y_ff;
      continuous_in   = continuous_ff;
      open_in         = open_ff;
      expected_in     = expected_ff;
      received_in     = received_ff;
      stored_count_in = stored_count_ff;
      scan_in         = scan_ff;
      scan_all_in     = scan_all_ff;
      seen_in         = seen_ff;
      stored_id_in    = stored_id_ff;
      stored_x_in     = stored_x_ff;
      stored_y_in     = stored_y_ff;
      cur_id_in       = cur_id_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_last_in     = rsp_last_ff;

      if (cmd.latch_item) begin
         item_cmd_in    = req_tuser;
         item_status_in = req_tdata[7:0];
         item_id_in     = req_tdata[15:8];
         item_x_in      = req_tdata[31:16];
         item_y_in      = req_tdata[47:32];
      end
      if (csr_wr_en) begin
         continuous_in = csr_wr_data;
      end
      if (cmd.frame_reset) begin
         open_in     = 1'b0;
         expected_in = '0;
         received_in = '0;
         seen_in     = '0;
      end
      if (cmd.frame_open) begin
         open_in     = 1'b1;
         expected_in = CW'(count);
      end
      if (cmd.record) begin
         for (int i = 0; i < MAX_POINTS; i++) begin
            if (CW'(i) == received_ff) begin
               cur_id_in[i] = item_id_ff;
               cur_x_in[i]  = item_x_ff;
               cur_y_in[i]  = item_y_ff;
            end
         end
         received_in = received_ff + 1'b1;
         seen_in     = seen_ff | match;
      end
      if (cmd.scan_start) begin
         scan_in     = '0;
         scan_all_in = cmd.scan_all;
      end
      if (cmd.scan_next) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.commit) begin
         for (int i = 0; i < MAX_POINTS; i++) begin
            if (CW'(i) < received_ff) begin
               stored_id_in[i] = cur_id_ff[i];
               stored_x_in[i]  = cur_x_ff[i];
               stored_y_in[i]  = cur_y_ff[i];
            end
         end
         stored_count_in = received_ff;
         open_in         = 1'b0;
         expected_in     = '0;
         received_in     = '0;
      end
      if (cmd.clear_stored) begin
         stored_count_in = '0;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_press) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tpt_pkg::KIND_PRESS;
         rsp_id_in    = item_id_ff;
         rsp_row_in   = item_y_ff;
         rsp_col_in   = item_x_ff;
         rsp_last_in  = !sts.frame_done;
      end
      if (cmd.load_release) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tpt_pkg::KIND_RELEASE;
         rsp_id_in    = sel_id;
         rsp_row_in   = sel_y;
         rsp_col_in   = sel_x;
         rsp_last_in  = 1'b0;
      end
      if (cmd.load_clear) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tpt_pkg::KIND_CLEAR;
         rsp_id_in    = '0;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         continuous_ff   <= 1'b1;
         open_ff         <= 1'b0;
         expected_ff     <= '0;
         received_ff     <= '0;
         stored_count_ff <= '0;
         scan_ff         <= '0;
         scan_all_ff     <= 1'b0;
         seen_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         continuous_ff   <= continuous_in;
         open_ff         <= open_in;
         expected_ff     <= expected_in;
         received_ff     <= received_in;
         stored_count_ff <= stored_count_in;
         scan_ff         <= scan_in;
         scan_all_ff     <= scan_all_in;
         seen_ff         <= seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff    <= item_cmd_in;
      item_status_ff <= item_status_in;
      item_id_ff     <= item_id_in;
      item_x_ff      <= item_x_in;
      item_y_ff      <= item_y_in;
      stored_id_ff   <= stored_id_in;
      stored_x_ff    <= stored_x_in;
      stored_y_ff    <= stored_y_in;
      cur_id_ff      <= cur_id_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_id_ff};

endmodule

>>> dv/touch_point_event_checker.sv
// ----------------------------------------------------------------------------
// Touch point event checker
// Watches the request, response and register ports of the tracker, keeps its
// own copy of the stored and current touch sets, predicts the press, release
// and status-clear events of every accepted item, and compares each accepted
// response against the oldest predicted event, field by field.
// ----------------------------------------------------------------------------
module touch_point_event_checker #(
   parameter int MAX_POINTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          events_pending
);

   localparam int FIELD_W = 16;

   typedef struct {
      logic [tpt_pkg::KIND_W-1:0]  kind;
      logic [tpt_pkg::ID_W-1:0]    id;
      logic [tpt_pkg::COORD_W-1:0] row;
      logic [tpt_pkg::COORD_W-1:0] column;
      logic                        last;
   } touch_event_type;

   touch_event_type events_due[$];

   logic                        continuous_mode;
   logic                        frame_open;
   int                          stored_count;
   int                          expected_count;
   int                          received_count;
   logic [tpt_pkg::ID_W-1:0]    stored_id [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0] stored_x  [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0] stored_y  [MAX_POINTS];
   logic [tpt_pkg::ID_W-1:0]    frame_id  [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0] frame_x   [MAX_POINTS];
   logic [tpt_pkg::COORD_W-1:0] frame_y   [MAX_POINTS];

   function automatic logic id_stored(logic [tpt_pkg::ID_W-1:0] id);
      for (int i = 0; i < stored_count; i++) begin
         if (stored_id[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic id_in_frame(logic [tpt_pkg::ID_W-1:0] id);
      for (int i = 0; i < received_count; i++) begin
         if (frame_id[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic post_event(logic [tpt_pkg::KIND_W-1:0] kind,
                             logic [tpt_pkg::ID_W-1:0] id,
                             logic [tpt_pkg::COORD_W-1:0] row,
                             logic [tpt_pkg::COORD_W-1:0] column);
      touch_event_type ev;
      ev.kind   = kind;
      ev.id     = id;
      ev.row    = row;
      ev.column = column;
      ev.last   = 1'b0;
      events_due.push_back(ev);
   endtask

   task automatic release_stored(logic only_missing);
      for (int i = 0; i < stored_count; i++) begin
         if (!only_missing || !id_in_frame(stored_id[i]))
            post_event(tpt_pkg::KIND_RELEASE, stored_id[i], stored_y[i], stored_x[i]);
      end
   endtask

   task automatic track_item(logic cmd, logic [tpt_pkg::STATUS_W-1:0] status,
                             logic [tpt_pkg::ID_W-1:0] id,
                             logic [tpt_pkg::COORD_W-1:0] x,
                             logic [tpt_pkg::COORD_W-1:0] y);
      int queued;
      int count;
      queued = events_due.size();
      count  = int'(status & tpt_pkg::COUNT_MASK);
      if (cmd == tpt_pkg::CMD_FRAME) begin
         frame_open     = 1'b0;
         expected_count = 0;
         received_count = 0;
         if (status == '0) begin
         end else if (!status[tpt_pkg::READY_BIT] || count > MAX_POINTS) begin
            post_event(tpt_pkg::KIND_CLEAR, '0, '0, '0);
         end else if (count == 0) begin
            release_stored(1'b0);
            stored_count = 0;
            post_event(tpt_pkg::KIND_CLEAR, '0, '0, '0);
         end else begin
            expected_count = count;
            frame_open     = 1'b1;
         end
      end else if (frame_open && received_count < MAX_POINTS) begin
         frame_id[received_count] = id;
         frame_x[received_count]  = x;
         frame_y[received_count]  = y;
         received_count++;
         if (continuous_mode || !id_stored(id)) post_event(tpt_pkg::KIND_PRESS, id, y, x);
         if (received_count >= expected_count) begin
            release_stored(1'b1);
            for (int i = 0; i < received_count; i++) begin
               stored_id[i] = frame_id[i];
               stored_x[i]  = frame_x[i];
               stored_y[i]  = frame_y[i];
            end
            stored_count   = received_count;
            frame_open     = 1'b0;
            expected_count = 0;
            received_count = 0;
            post_event(tpt_pkg::KIND_CLEAR, '0, '0, '0);
         end
      end
      if (events_due.size() > queued) events_due[events_due.size() - 1].last = 1'b1;
   endtask

   task automatic check_field(string field, logic [FIELD_W-1:0] want,
                              logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      touch_event_type due;
      if (reset) begin
         continuous_mode = 1'b1;
         frame_open      = 1'b0;
         stored_count    = 0;
         expected_count  = 0;
         received_count  = 0;
         for (int i = 0; i < MAX_POINTS; i++) begin
            stored_id[i] = '0;
            stored_x[i]  = '0;
            stored_y[i]  = '0;
         end
         events_due.delete();
      end else begin
         if (csr_wr_en) continuous_mode = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (events_due.size() == 0) begin
               $error("event_kind: expected none, actual %0d", rsp_tuser);
               fail_count++;
            end else begin
               due = events_due.pop_front();
               check_field("event_kind", FIELD_W'(due.kind), FIELD_W'(rsp_tuser));
               check_field("event_id", FIELD_W'(due.id), FIELD_W'(rsp_tdata[7:0]));
               check_field("row", due.row, rsp_tdata[23:8]);
               check_field("column", due.column, rsp_tdata[39:24]);
               check_field("last", FIELD_W'(due.last), FIELD_W'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            track_item(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[31:16],
                       req_tdata[47:32]);
      end
      events_pending <= events_due.size();
   end

endmodule

>>> dv/touch_point_press_release_tracker_tb.sv
// ----------------------------------------------------------------------------
// Touch point press/release tracker testbench
// Drives directed frames covering the status byte corner cases, dropped and
// duplicate-ID frames and the largest event bursts, then random phases of
// mostly well-formed frames with noise, in both tracking modes, with random
// gaps on both channels. The checker module predicts and compares events.
// ----------------------------------------------------------------------------
module touch_point_press_release_tracker_tb;

   localparam int MAX_POINTS    = 5;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 28;
   localparam int STATUS_W      = tpt_pkg::STATUS_W;
   localparam int ID_W          = tpt_pkg::ID_W;
   localparam int COORD_W       = tpt_pkg::COORD_W;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic        req_tuser   = tpt_pkg::CMD_FRAME;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   logic        gaps_on     = 1'b1;
   logic        req_took    = 1'b0;
   int          idle_cycles = 0;
   int          fail_count;
   int          events_pending;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   touch_point_press_release_tracker #(.MAX_POINTS(MAX_POINTS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   touch_point_event_checker #(.MAX_POINTS(MAX_POINTS)) event_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .events_pending(events_pending)
   );

   always @(negedge clock) begin
      rsp_tready = !(gaps_on && $urandom_range(0, 99) < 8);
   end

   always @(posedge clock) begin
      req_took <= req_tvalid && req_tready;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(logic cmd, logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      if (gaps_on && $urandom_range(0, 99) < 8) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {y, x, id, status};
      do @(negedge clock); while (!req_took);
   endtask

   task automatic send_frame(logic [STATUS_W-1:0] status);
      send_item(tpt_pkg::CMD_FRAME, status, ID_W'($urandom_range(0, 255)),
                COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic send_point(logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y);
      send_item(tpt_pkg::CMD_RECORD, STATUS_W'($urandom_range(0, 255)), id, x, y);
   endtask

   function automatic logic [STATUS_W-1:0] ready_status(int count);
      logic [STATUS_W-1:0] status;
      status = STATUS_W'($urandom_range(0, 255));
      status = (status & ~tpt_pkg::COUNT_MASK) | (STATUS_W'(count) & tpt_pkg::COUNT_MASK);
      status[tpt_pkg::READY_BIT] = 1'b1;
      return status;
   endfunction

   // Mostly a small ID pool so that frames overlap the stored set.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 3) != 0) return ID_W'($urandom_range(1, 8));
      return ID_W'($urandom_range(0, 255));
   endfunction

   task automatic drain();
      req_tvalid = 1'b0;
      while (events_pending != 0) @(negedge clock);
   endtask

   task automatic write_mode(logic mode);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic random_frames(int items);
      int sent;
      int pick;
      int count;
      int kept;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_POINTS);
            send_frame(ready_status(count));
            for (int k = 0; k < count; k++)
               send_point(pick_id(), COORD_W'($urandom), COORD_W'($urandom));
            sent += count + 1;
         end else if (pick < 88) begin
            count = $urandom_range(2, MAX_POINTS);
            kept  = $urandom_range(1, count - 1);
            send_frame(ready_status(count));
            for (int k = 0; k < kept; k++)
               send_point(pick_id(), COORD_W'($urandom), COORD_W'($urandom));
            sent += kept + 1;
         end else if (pick < 95) begin
            send_frame(STATUS_W'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_point(ID_W'($urandom_range(0, 255)), COORD_W'($urandom),
                       COORD_W'($urandom));
            sent++;
         end
         if ($urandom_range(0, 39) == 0) drain();
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send_point(8'h55, 16'h1234, 16'h5678);
      send_frame(8'h00);
      send_frame(8'h05);
      send_frame(8'h86);
      send_frame(8'h80);
      send_frame(8'h82);
      send_point(8'h00, 16'h0000, 16'h0000);
      send_point(8'hff, 16'hffff, 16'hffff);
      send_frame(8'hf3);
      send_point(8'h12, 16'haaaa, 16'h5555);
      send_frame(8'h81);
      send_point(8'h34, 16'h5555, 16'haaaa);
      send_frame(8'h85);
      send_point(8'h34, 16'h0101, 16'h0202);
      send_point(8'h34, 16'h0303, 16'h0404);
      send_point(8'h07, 16'h0505, 16'h0606);
      send_point(8'h08, 16'h0707, 16'h0808);
      send_point(8'h09, 16'h0909, 16'h0a0a);
      send_point(8'h66, 16'h1111, 16'h2222);
      send_frame(8'h8f);
      send_frame(8'h80);
      send_frame(8'h85);
      for (int k = 1; k <= MAX_POINTS; k++)
         send_point(ID_W'(k), COORD_W'($urandom), COORD_W'($urandom));
      send_frame(8'h81);
      send_point(8'h40, 16'hc3c3, 16'h3c3c);

      write_mode(1'b0);
      send_frame(8'h82);
      send_point(8'h21, 16'h0021, 16'h2100);
      send_point(8'h22, 16'h0022, 16'h2200);
      send_frame(8'h82);
      send_point(8'h21, 16'h0121, 16'h2101);
      send_point(8'h23, 16'h0023, 16'h2300);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_mode(phase % 2 == 0);
         gaps_on = (phase != 2);
         random_frames(PHASE_ITEMS);
      end

      drain();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
